>>> design/itq_pkg.sv
// Shared types, constants and a helper function for the IMU tilt/yaw quaternion unit.
`timescale 1ns / 1ps

package itq_pkg;

	localparam int DEF_CORDIC_STEPS = 16;
	localparam int DEF_ANGLE_BITS   = 16;

	// CORDIC x/y datapath width and multiplier operand width.
	localparam int CW = 36;
	localparam int MW = 33;

	localparam logic [31:0] GAIN_RESET = 32'd683565;
	localparam logic [31:0] KINV_Q30   = 32'd652032874;

	// Arctangent of 2^-i as a fraction of a full turn, 32 bits.
	localparam logic [31:0] ATAN_TURN32 [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// Register indexes of the configuration port.
	typedef enum logic [1:0] {
		REG_PITCH_OFS = 2'd0,
		REG_ROLL_OFS  = 2'd1,
		REG_YAW_GAIN  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] gyro_z;
		logic        [31:0] time_stamp;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_out;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
	} out_word_t;

	// Command from the sequencer to the shared CORDIC unit.
	typedef struct packed {
		logic start;
		logic vector_mode;
	} cordic_ctl_t;

	// Arctangent table entry rounded half up to an abits-wide binary angle.
	function automatic logic [31:0] atan_ang(logic [4:0] idx, int abits);
		logic [32:0] t;
		int          s;
		s = 32 - abits;
		t = {1'b0, ATAN_TURN32[idx]} + (33'd1 << (s - 1));
		return 32'(t >> s);
	endfunction

endpackage

>>> design/itq_cordic.sv
// Shared CORDIC unit, one micro-rotation per cycle, vectoring or rotation mode.
`timescale 1ns / 1ps

module itq_cordic #(
	parameter int CORDIC_STEPS = itq_pkg::DEF_CORDIC_STEPS,
	parameter int ANGLE_BITS   = itq_pkg::DEF_ANGLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  itq_pkg::cordic_ctl_t                ctl,
	input  logic signed [itq_pkg::CW-1:0]       x_in,
	input  logic signed [itq_pkg::CW-1:0]       y_in,
	input  logic signed [ANGLE_BITS+1:0]        z_in,
	output logic                                done,
	output logic signed [itq_pkg::CW-1:0]       x_out,
	output logic signed [itq_pkg::CW-1:0]       y_out,
	output logic signed [ANGLE_BITS+1:0]        z_out
);

	localparam int ZW = ANGLE_BITS + 2;
	localparam logic [4:0] LAST = 5'(CORDIC_STEPS - 1);

	logic signed [itq_pkg::CW-1:0] x_q, y_q, dx, dy;
	logic signed [ZW-1:0]          z_q, ang;
	logic [31:0]                   ang32;
	logic [4:0]                    cnt_q;
	logic                          busy_q, done_q, mode_q, add_dir;

	// One micro-rotation: the direction follows y in vectoring and z in rotation.
	always_comb begin
		dx      = y_q >>> cnt_q;
		dy      = x_q >>> cnt_q;
		ang32   = itq_pkg::atan_ang(cnt_q, ANGLE_BITS);
		ang     = ZW'(ang32);
		add_dir = mode_q ? !y_q[itq_pkg::CW-1] : z_q[ZW-1];
	end

	// Iteration registers and step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			mode_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				mode_q <= ctl.vector_mode;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q <= x_in;
			y_q <= y_in;
			z_q <= z_in;
		end else if (busy_q) begin
			if (add_dir) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ang;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ang;
			end
		end
	end

	assign done  = done_q;
	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;

endmodule

>>> design/imu_tilt_yaw_quaternion_unit.sv
// Top level: tilt, yaw and quaternion from one IMU sample, under a small sequencer.
// Each word goes through five passes of the one shared CORDIC unit, a 24-step square
// root and a registered multiplier shared by all products. One word is in work at a
// time: a new word is taken only once the sequencer is back in idle. Reset is
// asynchronous and active low; it clears yaw, the stored stamp, the sequencer,
// the output valid flag and the configuration registers.
`timescale 1ns / 1ps

module imu_tilt_yaw_quaternion_unit #(
	parameter int CORDIC_STEPS = itq_pkg::DEF_CORDIC_STEPS,
	parameter int ANGLE_BITS   = itq_pkg::DEF_ANGLE_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  itq_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output itq_pkg::out_word_t out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int A      = ANGLE_BITS;
	localparam int ZW     = A + 2;
	localparam int CW     = itq_pkg::CW;
	localparam int MW     = itq_pkg::MW;
	localparam int SH_UP  = (A >= 16) ? A - 16 : 0;
	localparam int SH_DN  = (A < 16) ? 16 - A : 0;
	localparam int RND_UP = (A > 16) ? (1 << (A - 17)) : 0;
	localparam int RND_DN = (A < 16) ? (1 << (15 - A)) : 0;
	localparam int S32    = 32 - A;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_SQ     = 11'b00000000010,
		S_SQRT   = 11'b00000000100,
		S_VROLL  = 11'b00000001000,
		S_VPITCH = 11'b00000010000,
		S_YAW    = 11'b00000100000,
		S_RROLL  = 11'b00001000000,
		S_RPITCH = 11'b00010000000,
		S_RYAW   = 11'b00100000000,
		S_QMUL   = 11'b01000000000,
		S_DONE   = 11'b10000000000
	} state_t;

	// Binary angle of A bits to 16 bits.
	function automatic logic [15:0] to16(logic [A-1:0] a);
		logic [24:0] t;
		t = 25'(a) + 25'(RND_UP);
		if (A >= 16) return 16'(t >> SH_UP);
		return 16'(a) << SH_DN;
	endfunction

	// 16-bit binary angle to A bits.
	function automatic logic [A-1:0] from16(logic [15:0] a);
		logic [16:0] t;
		t = 17'(a) + 17'(RND_DN);
		if (A >= 16) return A'(A'(a) << SH_UP);
		return A'(t >> SH_DN);
	endfunction

	// Signed half of an A-bit binary angle, floor.
	function automatic logic signed [ZW-1:0] half_ang(logic [A-1:0] a);
		logic signed [ZW-1:0] v;
		v = ZW'(signed'(a));
		return v >>> 1;
	endfunction

	// Q1.30 value to Q1.15, rounded half up and saturated.
	function automatic logic [15:0] toq15(logic signed [MW:0] v);
		logic signed [MW:0] r;
		r = (v + (MW+1)'(16384)) >>> 15;
		if (r > (MW+1)'(32767)) return 16'h7FFF;
		if (r < -(MW+1)'(32768)) return 16'h8000;
		return 16'(r);
	endfunction

	state_t                 state_q;
	logic [4:0]             k_q;
	itq_pkg::in_word_t      in_q;
	logic signed [15:0]     pitch_ofs_q, roll_ofs_q;
	logic [31:0]            yaw_gain_q, yaw_acc_q, prev_stamp_q;

	logic signed [MW-1:0]   mul_a, mul_b;
	logic signed [2*MW-1:0] prod_s1;
	logic signed [MW-1:0]   t30;

	logic [47:0]            rem_q, res_q, sq_bit, sq_try;
	logic [47:0]            m_q;
	logic                   neg_q;
	logic [65:0]            sum_q;
	logic [65:0]            q_full;
	logic [31:0]            yaw_inc, yaw_next;
	logic [31:0]            dt;
	logic [47:0]            p_abs;

	logic [15:0]            roll16_q, pitch16_q;
	logic signed [MW-1:0]   cr_q, sr_q, cp_q, sp_q, cy_q, sy_q;
	logic signed [MW-1:0]   crcp_q, srsp_q, srcp_q, crsp_q;
	logic signed [MW:0]     qx_q, qy_q, qz_q, qw_q;

	itq_pkg::cordic_ctl_t   cctl;
	logic                   cstart_q, c_done;
	logic signed [CW-1:0]   cx_in, cy_in, cx_out, cy_out;
	logic signed [ZW-1:0]   cz_in, cz_out;
	logic signed [CW-1:0]   roll_y, roll_x, pitch_y;
	logic [A-1:0]           c_ang, yaw_ang;
	logic                   roll_zero, pitch_zero;

	itq_pkg::out_word_t     out_q;
	logic                   out_valid_q;

	// Configuration registers and read-back.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_ofs_q <= '0;
			roll_ofs_q  <= '0;
			yaw_gain_q  <= itq_pkg::GAIN_RESET;
		end else if (psel && penable && pwrite) begin
			case (itq_pkg::reg_idx_t'(paddr[3:2]))
				itq_pkg::REG_PITCH_OFS: pitch_ofs_q <= pwdata[15:0];
				itq_pkg::REG_ROLL_OFS:  roll_ofs_q  <= pwdata[15:0];
				itq_pkg::REG_YAW_GAIN:  yaw_gain_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (itq_pkg::reg_idx_t'(paddr[3:2]))
			itq_pkg::REG_PITCH_OFS: prdata = {16'h0, pitch_ofs_q};
			itq_pkg::REG_ROLL_OFS:  prdata = {16'h0, roll_ofs_q};
			itq_pkg::REG_YAW_GAIN:  prdata = yaw_gain_q;
			default:                prdata = '0;
		endcase
	end

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQ: begin
				if (k_q == 5'd0) begin
					mul_a = MW'(in_q.accel_y);
					mul_b = MW'(in_q.accel_y);
				end else begin
					mul_a = MW'(in_q.accel_z);
					mul_b = MW'(in_q.accel_z);
				end
			end
			S_YAW: begin
				case (k_q)
					5'd0: begin mul_a = MW'(in_q.gyro_z); mul_b = {1'b0, dt}; end
					5'd2: begin mul_a = {1'b0, m_q[47:16]}; mul_b = MW'(yaw_gain_q[31:16]); end
					5'd3: begin mul_a = MW'(m_q[15:0]); mul_b = MW'(yaw_gain_q[31:16]); end
					5'd4: begin mul_a = {1'b0, m_q[47:16]}; mul_b = MW'(yaw_gain_q[15:0]); end
					5'd5: begin mul_a = MW'(m_q[15:0]); mul_b = MW'(yaw_gain_q[15:0]); end
					default: ;
				endcase
			end
			S_QMUL: begin
				case (k_q)
					5'd0:  begin mul_a = cr_q;   mul_b = cp_q; end
					5'd1:  begin mul_a = sr_q;   mul_b = sp_q; end
					5'd2:  begin mul_a = sr_q;   mul_b = cp_q; end
					5'd3:  begin mul_a = cr_q;   mul_b = sp_q; end
					5'd4:  begin mul_a = srcp_q; mul_b = cy_q; end
					5'd5:  begin mul_a = crsp_q; mul_b = sy_q; end
					5'd6:  begin mul_a = crsp_q; mul_b = cy_q; end
					5'd7:  begin mul_a = srcp_q; mul_b = sy_q; end
					5'd8:  begin mul_a = crcp_q; mul_b = sy_q; end
					5'd9:  begin mul_a = srsp_q; mul_b = cy_q; end
					5'd10: begin mul_a = crcp_q; mul_b = cy_q; end
					5'd11: begin mul_a = srsp_q; mul_b = sy_q; end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	// Product scaled back to Q1.30, floor.
	assign t30 = MW'(prod_s1 >>> 30);

	// Square root step, yaw arithmetic and angle helpers.
	always_comb begin
		sq_bit    = 48'd1 << (6'd46 - {k_q, 1'b0});
		sq_try    = res_q + sq_bit;
		dt        = in_q.time_stamp - prev_stamp_q;
		p_abs     = prod_s1[2*MW-1] ? 48'(-prod_s1) : prod_s1[47:0];
		q_full    = sum_q >> 16;
		yaw_inc   = neg_q ? (32'd0 - q_full[31:0]) : q_full[31:0];
		yaw_next  = (prev_stamp_q != 32'd0) ? (yaw_acc_q + yaw_inc) : yaw_acc_q;
		yaw_ang   = A'((({1'b0, yaw_acc_q} + (33'd1 << (S32 - 1))) >> S32));
		roll_y    = CW'(in_q.accel_y) <<< 16;
		roll_x    = CW'(in_q.accel_z) <<< 16;
		pitch_y   = -(CW'(in_q.accel_x) <<< 8);
		roll_zero  = (in_q.accel_y == 16'sd0) && (in_q.accel_z == 16'sd0);
		pitch_zero = (in_q.accel_x == 16'sd0) && (res_q == 48'd0);
		c_ang     = cz_out[A-1:0];
	end

	// CORDIC operands for the pass that the sequencer is in.
	always_comb begin
		cx_in = CW'(signed'({1'b0, itq_pkg::KINV_Q30}));
		cy_in = '0;
		cz_in = '0;
		unique case (state_q)
			S_VROLL: begin
				if (in_q.accel_z < 16'sd0) begin
					cx_in = -roll_x;
					cy_in = -roll_y;
					cz_in = ZW'(1) <<< (A - 1);
				end else begin
					cx_in = roll_x;
					cy_in = roll_y;
				end
			end
			S_VPITCH: begin
				cx_in = CW'(res_q[23:0]);
				cy_in = pitch_y;
			end
			S_RROLL:  cz_in = half_ang(from16(roll16_q));
			S_RPITCH: cz_in = half_ang(from16(pitch16_q));
			S_RYAW:   cz_in = half_ang(A'(-yaw_ang));
			default: ;
		endcase
	end

	assign cctl.start       = cstart_q;
	assign cctl.vector_mode = (state_q == S_VROLL) || (state_q == S_VPITCH);

	itq_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.ANGLE_BITS  (ANGLE_BITS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (cctl),
		.x_in  (cx_in),
		.y_in  (cy_in),
		.z_in  (cz_in),
		.done  (c_done),
		.x_out (cx_out),
		.y_out (cy_out),
		.z_out (cz_out)
	);

	// Sequencer and the state that persists across words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			k_q          <= '0;
			cstart_q     <= 1'b0;
			yaw_acc_q    <= '0;
			prev_stamp_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			cstart_q <= 1'b0;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SQ;
						k_q     <= '0;
					end
				end
				S_SQ: begin
					k_q <= k_q + 5'd1;
					if (k_q == 5'd2) begin
						state_q <= S_SQRT;
						k_q     <= '0;
					end
				end
				S_SQRT: begin
					k_q <= k_q + 5'd1;
					if (k_q == 5'd23) begin
						state_q  <= S_VROLL;
						cstart_q <= 1'b1;
					end
				end
				S_VROLL: begin
					if (c_done) begin
						state_q  <= S_VPITCH;
						cstart_q <= 1'b1;
					end
				end
				S_VPITCH: begin
					if (c_done) begin
						state_q <= S_YAW;
						k_q     <= '0;
					end
				end
				S_YAW: begin
					k_q <= k_q + 5'd1;
					if (k_q == 5'd7) begin
						yaw_acc_q    <= yaw_next;
						prev_stamp_q <= in_q.time_stamp;
						state_q      <= S_RROLL;
						cstart_q     <= 1'b1;
					end
				end
				S_RROLL: begin
					if (c_done) begin
						state_q  <= S_RPITCH;
						cstart_q <= 1'b1;
					end
				end
				S_RPITCH: begin
					if (c_done) begin
						state_q  <= S_RYAW;
						cstart_q <= 1'b1;
					end
				end
				S_RYAW: begin
					if (c_done) begin
						state_q <= S_QMUL;
						k_q     <= '0;
					end
				end
				S_QMUL: begin
					k_q <= k_q + 5'd1;
					if (k_q == 5'd12) state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of one word.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) in_q <= in_data;

		// Sum of squares, then the square root one bit per cycle.
		if (state_q == S_SQ) begin
			if (k_q == 5'd1) rem_q <= 48'(prod_s1[31:0]) << 16;
			if (k_q == 5'd2) rem_q <= rem_q + (48'(prod_s1[31:0]) << 16);
			res_q <= '0;
		end
		if (state_q == S_SQRT) begin
			if (rem_q >= sq_try) begin
				rem_q <= rem_q - sq_try;
				res_q <= (res_q >> 1) + sq_bit;
			end else begin
				res_q <= res_q >> 1;
			end
		end

		// Tilt angles less the offsets.
		if (state_q == S_VROLL && c_done)
			roll16_q <= (roll_zero ? 16'd0 : to16(c_ang)) - roll_ofs_q;
		if (state_q == S_VPITCH && c_done)
			pitch16_q <= (pitch_zero ? 16'd0 : to16(c_ang)) - pitch_ofs_q;

		// Yaw increment from partial products of |gyro*dt| and the gain.
		if (state_q == S_YAW) begin
			case (k_q)
				5'd1: begin
					m_q   <= p_abs;
					neg_q <= prod_s1[2*MW-1];
					sum_q <= '0;
				end
				5'd3: sum_q <= sum_q + (66'(prod_s1[63:0]) << 16);
				5'd4: sum_q <= sum_q + 66'(prod_s1[63:0]);
				5'd5: sum_q <= sum_q + 66'(prod_s1[63:0]);
				5'd6: sum_q <= sum_q + 66'(prod_s1[63:16]);
				default: ;
			endcase
		end

		// Half-angle sines and cosines.
		if (c_done) begin
			if (state_q == S_RROLL) begin
				cr_q <= MW'(cx_out);
				sr_q <= MW'(cy_out);
			end
			if (state_q == S_RPITCH) begin
				cp_q <= MW'(cx_out);
				sp_q <= MW'(cy_out);
			end
			if (state_q == S_RYAW) begin
				cy_q <= MW'(cx_out);
				sy_q <= MW'(cy_out);
			end
		end

		// Quaternion products, one consumed per cycle.
		if (state_q == S_QMUL) begin
			case (k_q)
				5'd1:  crcp_q <= t30;
				5'd2:  srsp_q <= t30;
				5'd3:  srcp_q <= t30;
				5'd4:  crsp_q <= t30;
				5'd5:  qx_q <= (MW+1)'(t30);
				5'd6:  qx_q <= qx_q - (MW+1)'(t30);
				5'd7:  qy_q <= (MW+1)'(t30);
				5'd8:  qy_q <= qy_q + (MW+1)'(t30);
				5'd9:  qz_q <= (MW+1)'(t30);
				5'd10: qz_q <= qz_q - (MW+1)'(t30);
				5'd11: qw_q <= (MW+1)'(t30);
				5'd12: qw_q <= qw_q + (MW+1)'(t30);
				default: ;
			endcase
		end

		// Result register.
		if (state_q == S_DONE && !out_valid_q) begin
			out_q.roll_angle  <= roll16_q;
			out_q.pitch_angle <= pitch16_q;
			out_q.yaw_out     <= yaw_acc_q[31:16];
			out_q.quat_x      <= toq15(qx_q);
			out_q.quat_y      <= toq15(qy_q);
			out_q.quat_z      <= toq15(qz_q);
			out_q.quat_w      <= toq15(qw_q);
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> design/itq_checker.sv
// Port-level checks of the IMU tilt/yaw quaternion unit, bound to the top level.
`timescale 1ns / 1ps

module itq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input itq_pkg::out_word_t out_data,
	input logic               pready
);

	// A word in work blocks the input side on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in work");

	// A taken result is cleared from the output register.
	a_out_drains: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid)
		else $error("result register refilled on the cycle it was taken");

	// A stalled result holds its word.
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// The configuration port never waits.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind imu_tilt_yaw_quaternion_unit itq_checker u_itq_checker (.*);

>>> dv/tb_imu_tilt_yaw_quaternion_unit.sv
// Self-checking testbench for the IMU tilt, yaw and quaternion unit.
`timescale 1ns / 1ps

module tb_imu_tilt_yaw_quaternion_unit;

	localparam int LATENCY = 160;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam logic [3:0] ADDR_UNUSED = 4'd12;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	itq_pkg::in_word_t in_data;
	itq_pkg::out_word_t out_data;
	logic psel, penable, pwrite, pready;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;

	// Model copy of the block's state and registers.
	logic [31:0] yaw_acc, last_stamp, yaw_gain_reg;
	logic [15:0] pitch_ofs_reg, roll_ofs_reg;
	itq_pkg::out_word_t pending_words[$];

	int errors = 0;
	int words_checked = 0;
	int settings_used = 0;
	longint cycles = 0;
	bit ready_always = 1'b0;
	bit no_gaps = 1'b0;
	bit hold_go = 1'b0;
	int hold_left = 0;

	imu_tilt_yaw_quaternion_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Arctangent step as a 16-bit binary angle, rounded half up.
	function automatic longint arc_step(int i);
		return (longint'(itq_pkg::ATAN_TURN32[i]) + 64'sd32768) >>> 16;
	endfunction

	// Vectoring CORDIC: angle of (x, y) as a 16-bit binary angle.
	function automatic logic [15:0] vector_angle(longint y, longint x);
		longint z, dx, dy;
		z = 0;
		if (x == 0 && y == 0) begin
			return 16'd0;
		end
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32768;
		end
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += arc_step(i);
			end else begin
				x -= dx; y += dy; z -= arc_step(i);
			end
		end
		return z[15:0];
	endfunction

	// Rotation CORDIC: cosine and sine in Q1.30 of a signed 16-bit angle.
	task automatic rotate_unit(input longint z, output longint c, output longint s);
		longint x, y, dx, dy;
		x = longint'(itq_pkg::KINV_Q30);
		y = 0;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= arc_step(i);
			end else begin
				x += dx; y -= dy; z += arc_step(i);
			end
		end
		c = x;
		s = y;
	endtask

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint half_of(logic [15:0] a);
		return longint'(signed'(a)) >>> 1;
	endfunction

	function automatic longint q30_mul(longint a, longint b);
		return (a * b) >>> 30;
	endfunction

	function automatic logic [15:0] to_q15(longint v);
		longint r;
		r = (v + 64'sd16384) >>> 15;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	// Computes the expected result word for one sample and advances yaw state.
	task automatic predict_pose(input itq_pkg::in_word_t d, output itq_pkg::out_word_t o);
		longint ax, ay, az, gz, p, cr, sr, cp, sp, cy, sy, crcp, srsp, srcp, crsp;
		longint unsigned m, q, r;
		logic [31:0] dt, inc;
		logic [15:0] roll16, pitch16, yaw_bam;
		ax = d.accel_x;
		ay = d.accel_y;
		az = d.accel_z;
		gz = d.gyro_z;
		roll16 = vector_angle(ay * 65536, az * 65536) - roll_ofs_reg;
		r = int_sqrt(longint'(ay * ay + az * az) << 16);
		pitch16 = vector_angle(-ax * 256, longint'(r)) - pitch_ofs_reg;
		if (last_stamp != 0) begin
			dt = d.time_stamp - last_stamp;
			p = gz * longint'(dt);
			m = (p < 0) ? -p : p;
			q = (m * yaw_gain_reg[31:16] + ((m * yaw_gain_reg[15:0]) >> 16)) >> 16;
			inc = (p < 0) ? (32'd0 - q[31:0]) : q[31:0];
			yaw_acc += inc;
		end
		last_stamp = d.time_stamp;
		yaw_bam = 16'(0 - ((longint'(yaw_acc) + 32768) >> 16));
		rotate_unit(half_of(roll16), cr, sr);
		rotate_unit(half_of(pitch16), cp, sp);
		rotate_unit(half_of(yaw_bam), cy, sy);
		crcp = q30_mul(cr, cp);
		srsp = q30_mul(sr, sp);
		srcp = q30_mul(sr, cp);
		crsp = q30_mul(cr, sp);
		o.roll_angle = roll16;
		o.pitch_angle = pitch16;
		o.yaw_out = yaw_acc[31:16];
		o.quat_x = to_q15(q30_mul(srcp, cy) - q30_mul(crsp, sy));
		o.quat_y = to_q15(q30_mul(crsp, cy) + q30_mul(srcp, sy));
		o.quat_z = to_q15(q30_mul(crcp, sy) - q30_mul(srsp, cy));
		o.quat_w = to_q15(q30_mul(crcp, cy) + q30_mul(srsp, sy));
	endtask

	// Gap before the next word: mostly none or short, sometimes long.
	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (no_gaps || k < 50) return 0;
		if (k < 94) return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	// Offers one word, waits for it to be taken and records its expected result.
	task automatic send_sample(input itq_pkg::in_word_t d);
		itq_pkg::out_word_t o;
		int gap;
		in_valid <= 1'b1;
		in_data <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_pose(d, o);
		pending_words.push_back(o);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_fields(input logic [15:0] ax, ay, az, gz, input logic [31:0] ts);
		itq_pkg::in_word_t d;
		d.accel_x = ax;
		d.accel_y = ay;
		d.accel_z = az;
		d.gyro_z = gz;
		d.time_stamp = ts;
		send_sample(d);
	endtask

	// Stops offering words and waits until every expected result has arrived.
	task automatic drain_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	// Register write through the setup and access phases.
	task automatic reg_write(input logic [3:0] addr, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (addr)
			{itq_pkg::REG_PITCH_OFS, 2'b00}: pitch_ofs_reg = val[15:0];
			{itq_pkg::REG_ROLL_OFS, 2'b00}: roll_ofs_reg = val[15:0];
			{itq_pkg::REG_YAW_GAIN, 2'b00}: yaw_gain_reg = val;
			default: ;
		endcase
	endtask

	task automatic set_registers(input logic [15:0] pofs, rofs, input logic [31:0] gain);
		reg_write({itq_pkg::REG_PITCH_OFS, 2'b00}, {16'd0, pofs});
		reg_write({itq_pkg::REG_ROLL_OFS, 2'b00}, {16'd0, rofs});
		reg_write({itq_pkg::REG_YAW_GAIN, 2'b00}, gain);
		settings_used++;
	endtask

	function automatic logic [15:0] pick_axis();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(0, 15)) - 16'd8;
			3: return 16'($urandom_range(0, 511)) - 16'd256;
			default: return 16'($urandom());
		endcase
	endfunction

	// One random sample; stamps mostly move forward, sometimes jump, go back or hit zero.
	logic [31:0] stamp_now = 32'd1000;
	task automatic send_random();
		case ($urandom_range(0, 19))
			0: stamp_now = 32'd0;
			1: stamp_now = stamp_now - 32'($urandom_range(1, 100000));
			2: stamp_now = $urandom();
			default: stamp_now = stamp_now + 32'($urandom_range(1, 20000));
		endcase
		send_fields(pick_axis(), pick_axis(), pick_axis(), pick_axis(), stamp_now);
	endtask

	// Edge cases of the angle math and the yaw timing.
	task automatic test_directed();
		send_fields(16'd0, 16'd0, 16'd0, 16'd0, 32'd0);
		send_fields(16'd0, 16'd0, 16'd1000, 16'd0, 32'd0);
		send_fields(16'd0, 16'd0, 16'h8000, 16'd0, 32'd100);
		send_fields(16'd0, 16'd1, 16'h8000, 16'h7FFF, 32'd200);
		send_fields(16'd0, 16'hFFFF, 16'h8000, 16'h8000, 32'd300);
		send_fields(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 32'd1300);
		send_fields(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 32'd2300);
		send_fields(16'h8000, 16'd0, 16'd0, 16'd4096, 32'd50000);
		send_fields(16'h7FFF, 16'd0, 16'd0, 16'd4096, 32'd40000);
		send_fields(16'd0, 16'h7FFF, 16'd0, 16'hF000, 32'hFFFF_FFF0);
		send_fields(16'd0, 16'h8000, 16'd0, 16'h1000, 32'd16);
		send_fields(16'd5, 16'd0, 16'h8000, 16'h7FFF, 32'd0);
		send_fields(16'd0, 16'd0, 16'd0, 16'h7FFF, 32'hFFFF_FFFF);
		send_fields(16'd0, 16'd1, 16'd1, 16'h8000, 32'd1);
		send_fields(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h8000_0000);
		drain_block();
	endtask

	// Samples under each register setting, extremes included.
	task automatic test_register_sweep();
		set_registers(16'h8000, 16'h7FFF, 32'hFFFF_FFFF);
		repeat (25) send_random();
		drain_block();
		set_registers(16'h7FFF, 16'h8000, 32'd0);
		repeat (25) send_random();
		drain_block();
		reg_write(ADDR_UNUSED, 32'hDEAD_BEEF);
		set_registers(16'($urandom()), 16'($urandom()), $urandom());
		repeat (25) send_random();
		drain_block();
	endtask

	// Long stall at the receiver while words keep coming, then a full pause.
	task automatic test_backpressure();
		hold_go = 1'b1;
		no_gaps = 1'b1;
		repeat (12) send_random();
		no_gaps = 1'b0;
		drain_block();
	endtask

	// Bulk random traffic, with and without idle stretches, across settings.
	task automatic test_random();
		for (int phase = 0; phase < 8; phase++) begin
			ready_always = (phase % 3 == 0);
			no_gaps = (phase % 4 == 1);
			repeat (50) send_random();
			drain_block();
			if (phase == 3) begin
				set_registers(16'd0, 16'd0, itq_pkg::GAIN_RESET);
			end else begin
				set_registers(16'($urandom()), 16'($urandom()), $urandom());
			end
		end
		ready_always = 1'b0;
		no_gaps = 1'b0;
	endtask

	// Receiver side: random stalls, plus a long hold counted here when asked.
	always @(posedge clk) begin
		if (hold_go) begin
			hold_go = 1'b0;
			hold_left = 600;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (ready_always) begin
			out_ready <= 1'b1;
		end else begin
			if ($urandom_range(0, 199) == 0) hold_left = $urandom_range(20, 120);
			out_ready <= ($urandom_range(0, 9) < 7);
		end
	end

	task automatic check_field(input string name, input logic [15:0] exp_v, act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, signed'(exp_v), signed'(act_v));
			errors++;
		end
	endtask

	// Compares each result word taken with the oldest expected one.
	always @(posedge clk) begin
		itq_pkg::out_word_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				e = pending_words.pop_front();
				check_field("roll_angle", e.roll_angle, out_data.roll_angle);
				check_field("pitch_angle", e.pitch_angle, out_data.pitch_angle);
				check_field("yaw_out", e.yaw_out, out_data.yaw_out);
				check_field("quat_x", e.quat_x, out_data.quat_x);
				check_field("quat_y", e.quat_y, out_data.quat_y);
				check_field("quat_z", e.quat_z, out_data.quat_z);
				check_field("quat_w", e.quat_w, out_data.quat_w);
				words_checked++;
			end
		end
	end

	// Run timeout.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		yaw_acc = '0;
		last_stamp = '0;
		pitch_ofs_reg = '0;
		roll_ofs_reg = '0;
		yaw_gain_reg = itq_pkg::GAIN_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_sweep();
		test_backpressure();
		test_random();
		if (pending_words.size() != 0) begin
			$error("%0d expected words never arrived", pending_words.size());
			errors++;
		end
		$display("Checked %0d result words over %0d register settings, with stalls and gaps.",
			words_checked, settings_used);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
